FILE: hdl/itda_pkg.sv
// ----------------------------------------------------------------------------
// Integer to decimal ASCII package
// Shared types and character constants for the integer to ASCII converter.
// ----------------------------------------------------------------------------
`default_nettype none

package itda_pkg;

    localparam int IN_DATA_W = 64;
    localparam int CHAR_W    = 8;

    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_SKIP,
        S_SPACE,
        S_MINUS,
        S_DIGIT
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
        logic shift_digit;
    } t_dd_cmd;

    typedef struct packed {
        logic              valid;
        logic [CHAR_W-1:0] char_code;
        logic              last;
    } t_emit;

endpackage

`default_nettype wire

FILE: hdl/itda_dabble.sv
// ----------------------------------------------------------------------------
// Shift-and-add-3 binary to BCD unit
// Converts one magnitude a bit per cycle and then hands out its digits,
// most significant first, one digit shift at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module itda_dabble
    import itda_pkg::*;
#(
    parameter int VALUE_WIDTH = 64,
    parameter int NDIG        = 20
) (
    input  wire logic                   i_clk,
    input  wire t_dd_cmd                i_cmd,
    input  wire logic [VALUE_WIDTH-1:0] i_value,
    output logic      [3:0]             o_top_digit
);

    logic [VALUE_WIDTH-1:0] r_bin;
    logic [4*NDIG-1:0]      r_bcd;
    logic [4*NDIG-1:0]      w_adj;

    always_comb begin
        logic [3:0] d;
        d     = '0;
        w_adj = '0;
        for (int k = 0; k < NDIG; k++) begin
            d = r_bcd[4*k +: 4];
            w_adj[4*k +: 4] = (d >= 4'd5) ? d + 4'd3 : d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_bin <= i_value;
            r_bcd <= '0;
        end else if (i_cmd.step) begin
            r_bin <= {r_bin[VALUE_WIDTH-2:0], 1'b0};
            r_bcd <= {w_adj[4*NDIG-2:0], r_bin[VALUE_WIDTH-1]};
        end else if (i_cmd.shift_digit) begin
            r_bcd <= {r_bcd[4*NDIG-5:0], 4'b0000};
        end
    end

    assign o_top_digit = r_bcd[4*NDIG-1 -: 4];

endmodule

`default_nettype wire

FILE: hdl/itda_ctrl.sv
// ----------------------------------------------------------------------------
// Converter sequencer
// Steps the BCD unit, drops leading zero digits and emits the characters.
// ----------------------------------------------------------------------------
`default_nettype none

module itda_ctrl
    import itda_pkg::*;
#(
    parameter int VALUE_WIDTH = 64,
    parameter int NDIG        = 20
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic       i_neg,
    input  wire logic [3:0] i_top_digit,
    input  wire logic       i_out_free,
    output logic            o_in_ready,
    output t_dd_cmd         o_cmd,
    output t_emit           o_emit
);

    localparam int BCW = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;
    localparam int DCW = $clog2(NDIG + 1);

    t_state         r_state, n_state;
    logic [BCW-1:0] r_bit_cnt, n_bit_cnt;
    logic [DCW-1:0] r_dig_left, n_dig_left;
    logic           w_last_bit;
    logic           w_skip;

    assign w_last_bit = (r_bit_cnt == BCW'(VALUE_WIDTH - 1));
    assign w_skip     = (i_top_digit == 4'd0) && (r_dig_left > DCW'(1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_CONV;
            S_CONV:  if (w_last_bit) n_state = S_SKIP;
            S_SKIP:  if (!w_skip) n_state = S_SPACE;
            S_SPACE: if (i_out_free) n_state = i_neg ? S_MINUS : S_DIGIT;
            S_MINUS: if (i_out_free) n_state = S_DIGIT;
            S_DIGIT: if (i_out_free && (r_dig_left == DCW'(1))) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready  = 1'b0;
        o_cmd       = '0;
        o_emit      = '0;
        n_bit_cnt   = r_bit_cnt;
        n_dig_left  = r_dig_left;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
                n_bit_cnt  = '0;
            end
            S_CONV: begin
                o_cmd.step = 1'b1;
                n_bit_cnt  = r_bit_cnt + BCW'(1);
                n_dig_left = DCW'(NDIG);
            end
            S_SKIP: begin
                if (w_skip) begin
                    o_cmd.shift_digit = 1'b1;
                    n_dig_left        = r_dig_left - DCW'(1);
                end
            end
            S_SPACE: begin
                o_emit.valid     = i_out_free;
                o_emit.char_code = CHAR_SPACE;
            end
            S_MINUS: begin
                o_emit.valid     = i_out_free;
                o_emit.char_code = CHAR_MINUS;
            end
            S_DIGIT: begin
                o_emit.valid      = i_out_free;
                o_emit.char_code  = CHAR_ZERO + {4'b0000, i_top_digit};
                o_emit.last       = (r_dig_left == DCW'(1));
                o_cmd.shift_digit = i_out_free;
                if (i_out_free) begin
                    n_dig_left = r_dig_left - DCW'(1);
                end
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_bit_cnt  <= n_bit_cnt;
        r_dig_left <= n_dig_left;
    end

endmodule

`default_nettype wire

FILE: hdl/integer_to_decimal_ascii_top.sv
// ----------------------------------------------------------------------------
// Integer to decimal ASCII converter
// Turns one integer into a space, an optional minus sign and its decimal
// digits, one ASCII character per output item.
//
// The input channel takes one integer in s_axis_tdata with the signedness
// mode in s_axis_tuser. Only the low VALUE_WIDTH bits of the value are used.
// The output channel gives one character per item in m_axis_tdata, with
// m_axis_tlast high on the final digit of each number.
// An accepted number is converted by a shift-and-add-3 unit, one bit per
// cycle. Leading zero digits are then dropped at one per cycle, after which
// the sequencer finds the first digit to print. After that one character
// leaves per cycle while the receiver takes them, 2 to 21 for 64 bits.
// Skipped and printed digits add up to 20 for 64 bits.
// The block takes a new number only once every character of the previous
// one has been handed to the output register. When the receiver stalls,
// the pending character holds in that register and the sequencer waits.
// Reset returns the sequencer to idle and empties the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_to_decimal_ascii_top
    import itda_pkg::*;
#(
    parameter int VALUE_WIDTH = 64
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [IN_DATA_W-1:0] s_axis_tdata,  // value
    input  wire logic                 s_axis_tuser,  // mode
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic      [CHAR_W-1:0]    m_axis_tdata,  // character
    output logic                      m_axis_tlast
);

    localparam int NDIG = (VALUE_WIDTH * 30103) / 100000 + 1;

    logic [VALUE_WIDTH-1:0] w_value;
    logic                   w_neg;
    logic [VALUE_WIDTH-1:0] w_mag;
    logic                   w_accept;
    logic                   w_out_free;
    logic [3:0]             w_top_digit;
    t_dd_cmd                w_cmd;
    t_emit                  w_emit;

    logic                   r_neg;
    logic                   r_out_valid;
    logic [CHAR_W-1:0]      r_out_char;
    logic                   r_out_last;

    assign w_value    = s_axis_tdata[VALUE_WIDTH-1:0];
    assign w_neg      = s_axis_tuser & w_value[VALUE_WIDTH-1];
    assign w_mag      = w_neg ? (~w_value + {{(VALUE_WIDTH-1){1'b0}}, 1'b1}) : w_value;
    assign w_accept   = s_axis_tvalid & s_axis_tready;
    assign w_out_free = !r_out_valid || m_axis_tready;

    itda_ctrl #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .NDIG        (NDIG)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_neg       (r_neg),
        .i_top_digit (w_top_digit),
        .i_out_free  (w_out_free),
        .o_in_ready  (s_axis_tready),
        .o_cmd       (w_cmd),
        .o_emit      (w_emit)
    );

    itda_dabble #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .NDIG        (NDIG)
    ) u_dabble (
        .i_clk       (i_clk),
        .i_cmd       (w_cmd),
        .i_value     (w_mag),
        .o_top_digit (w_top_digit)
    );

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_neg <= w_neg;
        end
        if (w_emit.valid) begin
            r_out_char <= w_emit.char_code;
            r_out_last <= w_emit.last;
        end
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit.valid) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_char;
    assign m_axis_tlast  = r_out_last;

endmodule

`default_nettype wire
